@@ rtl/core/lcbb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbb_pkg: shared types and constants
// Request/response structs, table geometry and action codes.
// ----------------------------------------------------------------------------
package lcbb_pkg;

  localparam int Entries    = 16;
  localparam int IdxW       = $clog2(Entries);
  localparam int CntW       = $clog2(Entries + 1);
  localparam int KeyW       = 32;
  localparam int ValW       = 32;
  localparam int CostW      = 17;
  localparam int UsageW     = 21;
  localparam int EvW        = 5;
  localparam int AddrW      = 2;
  localparam logic [CostW-1:0]  Overhead  = CostW'(64);
  localparam logic [UsageW-1:0] BudgetRst = UsageW'(1048576);

  typedef enum logic [1:0] {
    ACT_SET = 2'd0,
    ACT_GET = 2'd1,
    ACT_DEL = 2'd2,
    ACT_NOP = 2'd3
  } action_t;

  localparam logic [AddrW-1:0] REG_BUDGET = AddrW'(0);

  typedef struct packed {
    logic [1:0]       action;
    logic [KeyW-1:0]  key;
    logic [ValW-1:0]  value_in;
    logic [15:0]      payload_bytes;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [ValW-1:0]   value_out;
    logic [UsageW-1:0] memory_usage;
    logic [EvW-1:0]    evicted_count;
  } rsp_t;

  // commands from the sequencer to the table
  typedef struct packed {
    logic            touch;   // make slot most recent
    logic            drop;    // remove slot
    logic            insert;  // write new key into slot as most recent
    logic            update;  // rewrite value and cost of slot
    logic [IdxW-1:0] slot;
  } tbl_cmd_t;

  // status from the table to the sequencer
  typedef struct packed {
    logic            match;
    logic [IdxW-1:0] match_slot;
    logic [ValW-1:0] match_value;
    logic [CostW-1:0] match_cost;
    logic            any_valid;
    logic            full;
    logic [IdxW-1:0] free_slot;
    logic [IdxW-1:0] oldest_slot;
    logic [CostW-1:0] oldest_cost;
  } tbl_stat_t;

endpackage

@@ rtl/core/lcbb_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbb_table: entry storage with recency ranks
// Holds keys, values, costs and ranks; applies one command per cycle.
// ----------------------------------------------------------------------------
module lcbb_table import lcbb_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [KeyW-1:0] key,
  input  logic [ValW-1:0] value_in,
  input  logic [CostW-1:0] cost,
  input  tbl_cmd_t        cmd,
  output tbl_stat_t       stat
);

  logic [Entries-1:0]   valid_r, valid_nxt;
  logic [IdxW-1:0]      rank_r [Entries];
  logic [IdxW-1:0]      rank_nxt [Entries];
  logic [KeyW-1:0]      key_r [Entries];
  logic [ValW-1:0]      val_r [Entries];
  logic [CostW-1:0]     cost_r [Entries];

  // the oldest valid entry holds rank count-1, so an equality search suffices
  logic [CntW-1:0] nvalid;
  logic [IdxW-1:0] oldest_rank;
  logic [IdxW-1:0] ref_rank;

  always_comb begin
    nvalid = '0;
    for (int i = 0; i < Entries; i++) begin
      nvalid = nvalid + CntW'(valid_r[i]);
    end
    oldest_rank = IdxW'(nvalid - CntW'(1));
    stat = '0;
    stat.any_valid = |valid_r;
    stat.full      = &valid_r;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        stat.free_slot = IdxW'(i);
      end
    end
    for (int i = 0; i < Entries; i++) begin
      if (valid_r[i] && key_r[i] == key) begin
        stat.match       = 1'b1;
        stat.match_slot  = IdxW'(i);
        stat.match_value = val_r[i];
        stat.match_cost  = cost_r[i];
      end
      if (valid_r[i] && rank_r[i] == oldest_rank) begin
        stat.oldest_slot = IdxW'(i);
        stat.oldest_cost = cost_r[i];
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    ref_rank  = rank_r[cmd.slot];
    for (int i = 0; i < Entries; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (cmd.touch) begin
      for (int i = 0; i < Entries; i++) begin
        if (valid_r[i] && rank_r[i] < ref_rank) rank_nxt[i] = rank_r[i] + 1'b1;
      end
      rank_nxt[cmd.slot] = '0;
    end else if (cmd.drop) begin
      for (int i = 0; i < Entries; i++) begin
        if (valid_r[i] && rank_r[i] > ref_rank) rank_nxt[i] = rank_r[i] - 1'b1;
      end
      valid_nxt[cmd.slot] = 1'b0;
      rank_nxt[cmd.slot]  = '0;
    end else if (cmd.insert) begin
      for (int i = 0; i < Entries; i++) begin
        if (valid_r[i]) rank_nxt[i] = rank_r[i] + 1'b1;
      end
      valid_nxt[cmd.slot] = 1'b1;
      rank_nxt[cmd.slot]  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < Entries; i++) rank_r[i] <= '0;
    end else begin
      valid_r <= valid_nxt;
      for (int i = 0; i < Entries; i++) rank_r[i] <= rank_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      key_r[cmd.slot] <= key;
    end
    if (cmd.insert || cmd.update) begin
      val_r[cmd.slot]  <= value_in;
      cost_r[cmd.slot] <= cost;
    end
  end

endmodule

@@ rtl/core/lcbb_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbb_seq: request sequencer
// Steps a request through lookup, then evictions and insert on a set miss or
// a done step otherwise, using one shared usage adder/subtractor and a separate budget comparator.
// ----------------------------------------------------------------------------
module lcbb_seq import lcbb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  req_t              in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output rsp_t              out_rsp,
  input  logic [UsageW-1:0] budget,
  output logic [KeyW-1:0]   key,
  output logic [ValW-1:0]   value,
  output logic [CostW-1:0]  cost,
  output tbl_cmd_t          cmd,
  input  tbl_stat_t         stat,
  output logic              busy
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOOK  = 4'b0010,
    ST_EVICT = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  req_t              req_r;
  logic [UsageW-1:0] usage_r, usage_nxt;
  logic [EvW-1:0]    ev_r, ev_nxt;
  logic              hit_r, hit_nxt;
  logic [ValW-1:0]   vout_r, vout_nxt;
  logic              ovalid_r, ovalid_nxt;

  // shared unit: saturating usage add/sub; the budget compare has its own adder
  logic [UsageW-1:0] opa;
  logic [CostW-1:0]  opb;
  logic              op_sub;
  logic [UsageW:0]   sum;
  logic [UsageW-1:0] res;
  logic              over;

  assign cost  = CostW'(req_r.payload_bytes) + Overhead;
  assign key   = req_r.key;
  assign value = req_r.value_in;

  always_comb begin
    sum = op_sub ? ({1'b0, opa} - {{(UsageW-CostW+1){1'b0}}, opb})
                 : ({1'b0, opa} + {{(UsageW-CostW+1){1'b0}}, opb});
    if (op_sub) res = sum[UsageW] ? '0 : sum[UsageW-1:0];
    else        res = sum[UsageW] ? '1 : sum[UsageW-1:0];
    // budget check always on current usage plus the new cost
    over = ({1'b0, usage_r} + {{(UsageW-CostW+1){1'b0}}, cost}) > {1'b0, budget};
  end

  always_comb begin
    state_nxt  = state_r;
    usage_nxt  = usage_r;
    ev_nxt     = ev_r;
    hit_nxt    = hit_r;
    vout_nxt   = vout_r;
    ovalid_nxt = ovalid_r;
    cmd        = '0;
    opa        = usage_r;
    opb        = cost;
    op_sub     = 1'b0;
    if (ovalid_r && !out_stall) ovalid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          state_nxt = ST_LOOK;
          ev_nxt    = '0;
          vout_nxt  = '0;
        end
      end
      ST_LOOK: begin
        hit_nxt = stat.match && (req_r.action != ACT_NOP);
        case (action_t'(req_r.action))
          ACT_SET: begin
            if (stat.match) begin
              // replace: sub old cost now, add new cost in done step
              cmd.touch  = 1'b1;
              cmd.update = 1'b1;
              cmd.slot   = stat.match_slot;
              opb        = stat.match_cost;
              op_sub     = 1'b1;
              usage_nxt  = res;
              state_nxt  = ST_DONE;
            end else begin
              state_nxt = ST_EVICT;
            end
          end
          ACT_GET: begin
            if (stat.match) begin
              cmd.touch = 1'b1;
              cmd.slot  = stat.match_slot;
              vout_nxt  = stat.match_value;
            end
            state_nxt = ST_DONE;
          end
          ACT_DEL: begin
            if (stat.match) begin
              cmd.drop  = 1'b1;
              cmd.slot  = stat.match_slot;
              opb       = stat.match_cost;
              op_sub    = 1'b1;
              usage_nxt = res;
            end
            state_nxt = ST_DONE;
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_EVICT: begin
        if (stat.any_valid && (over || stat.full)) begin
          cmd.drop  = 1'b1;
          cmd.slot  = stat.oldest_slot;
          opb       = stat.oldest_cost;
          op_sub    = 1'b1;
          usage_nxt = res;
          if (ev_r != '1) ev_nxt = ev_r + 1'b1;
        end else begin
          cmd.insert = 1'b1;
          cmd.slot   = stat.free_slot;
          usage_nxt  = res;
          state_nxt  = ST_IDLE;
          ovalid_nxt = 1'b1;
        end
      end
      ST_DONE: begin
        if (req_r.action == ACT_SET) usage_nxt = res;
        state_nxt  = ST_IDLE;
        ovalid_nxt = 1'b1;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // new request only when the result slot is free
  assign in_stall = (state_r != ST_IDLE) || ovalid_r;
  assign busy     = state_r != ST_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      usage_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= (state_r == ST_IDLE && in_stall) ? ST_IDLE : state_nxt;
      usage_r  <= usage_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid && !in_stall) req_r <= in_req;
    ev_r   <= ev_nxt;
    hit_r  <= hit_nxt;
    vout_r <= vout_nxt;
  end

  assign out_valid = ovalid_r;
  always_comb begin
    out_rsp.hit           = hit_r;
    out_rsp.value_out     = vout_r;
    out_rsp.memory_usage  = usage_r;
    out_rsp.evicted_count = ev_r;
  end

endmodule

@@ rtl/core/lru_cache_byte_budget_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_byte_budget_top: lru key-value table under a byte budget
// Get/delete/no-op and set-hit step through lookup and a done step; set-miss
// steps through lookup, then one eviction per cycle through the shared usage
// adder, then the insert. One request at a time; next accepted after result
// is taken. Synchronous reset empties the table, zeroes usage, budget 1048576.
// ----------------------------------------------------------------------------
module lru_cache_byte_budget_top import lcbb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  req_t             in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rsp_t             out_data,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [AddrW-1:0] cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [UsageW-1:0] budget_r;
  logic [KeyW-1:0]   t_key;
  logic [ValW-1:0]   t_val;
  logic [CostW-1:0]  t_cost;
  tbl_cmd_t          cmd;
  tbl_stat_t         stat;
  logic              busy;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_BUDGET) ? 32'(budget_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= BudgetRst;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_BUDGET) begin
      budget_r <= cfg_pwdata[UsageW-1:0];
    end
  end

  lcbb_seq u_seq (
    .clk, .rst_n, .in_valid, .in_stall, .in_req(in_data),
    .out_valid, .out_stall, .out_rsp(out_data), .budget(budget_r),
    .key(t_key), .value(t_val), .cost(t_cost), .cmd, .stat, .busy
  );

  lcbb_table u_tbl (
    .clk, .rst_n, .key(t_key), .value_in(t_val), .cost(t_cost), .cmd, .stat
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.touch, cmd.drop, cmd.insert}) <= 1)
    else $error("multiple table commands");
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> in_stall)
    else $error("input open while busy");
  a_evict_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drop |-> stat.any_valid)
    else $error("drop on empty table");
  a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> !stat.full)
    else $error("insert into full table");

endmodule

@@ verif/lru_cache_byte_budget_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_byte_budget_top_tb: request/response check of the lru byte table
// Drives set/get/delete/no-op requests with random gaps and output stalls, keeps a
// behavioral copy of the table to predict each response, and compares them
// field by field. The byte budget is changed between phases while idle.
// ----------------------------------------------------------------------------
module lru_cache_byte_budget_top_tb;
  import lcbb_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  req_t             in_data;
  logic             out_valid;
  logic             out_stall;
  rsp_t             out_data;
  logic             cfg_psel;
  logic             cfg_penable;
  logic             cfg_pwrite;
  logic [AddrW-1:0] cfg_paddr;
  logic [31:0]      cfg_pwdata;
  logic [31:0]      cfg_prdata;
  logic             cfg_pready;

  lru_cache_byte_budget_top dut (.*);

  // table copy
  logic              tbl_valid [Entries];
  logic [KeyW-1:0]   tbl_key   [Entries];
  logic [ValW-1:0]   tbl_val   [Entries];
  logic [CostW-1:0]  tbl_cost  [Entries];
  int unsigned       tbl_rank  [Entries];
  int unsigned       usage;
  int unsigned       budget;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors;
  int   rsp_count;
  int   evict_total;
  int   idle_cycles;
  int unsigned in_gap;
  int unsigned out_gap;
  logic [KeyW-1:0] key_pool[8];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic int find_slot(logic [KeyW-1:0] k);
    for (int i = 0; i < Entries; i++)
      if (tbl_valid[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < Entries; i++) if (tbl_valid[i]) n++;
    return n;
  endfunction

  function automatic void make_recent(int s);
    for (int i = 0; i < Entries; i++)
      if (tbl_valid[i] && tbl_rank[i] < tbl_rank[s]) tbl_rank[i]++;
    tbl_rank[s] = 0;
  endfunction

  function automatic void remove_slot(int s);
    usage = (tbl_cost[s] > usage) ? 0 : usage - tbl_cost[s];
    tbl_valid[s] = 1'b0;
    for (int i = 0; i < Entries; i++)
      if (tbl_valid[i] && tbl_rank[i] > tbl_rank[s]) tbl_rank[i]--;
    tbl_rank[s] = 0;
  endfunction

  function automatic void evict_lru();
    int best;
    best = -1;
    for (int i = 0; i < Entries; i++)
      if (tbl_valid[i] && (best < 0 || tbl_rank[i] > tbl_rank[best])) best = i;
    if (best >= 0) remove_slot(best);
  endfunction

  function automatic void charge(int unsigned c);
    usage = (usage + c > 2097151) ? 2097151 : usage + c;
  endfunction

  function automatic rsp_t predict_lookup(req_t r);
    rsp_t        p;
    int          s;
    int          ev;
    int          f;
    int unsigned c;
    s  = find_slot(r.key);
    ev = 0;
    c  = r.payload_bytes + 64;
    p  = '0;
    p.hit = (r.action != ACT_NOP) && (s >= 0);
    case (action_t'(r.action))
      ACT_SET: begin
        if (s >= 0) begin
          usage = (tbl_cost[s] > usage) ? 0 : usage - tbl_cost[s];
          charge(c);
          tbl_val[s]  = r.value_in;
          tbl_cost[s] = c;
          make_recent(s);
        end else begin
          while (live_count() > 0 && usage + c > budget) begin
            evict_lru();
            ev++;
          end
          if (live_count() >= Entries) begin
            evict_lru();
            ev++;
          end
          for (int i = 0; i < Entries; i++) if (tbl_valid[i]) tbl_rank[i]++;
          f = -1;
          for (int i = Entries - 1; i >= 0; i--) if (!tbl_valid[i]) f = i;
          if (f >= 0) begin
            tbl_valid[f] = 1'b1;
            tbl_key[f]   = r.key;
            tbl_val[f]   = r.value_in;
            tbl_cost[f]  = c;
            tbl_rank[f]  = 0;
            charge(c);
          end
        end
      end
      ACT_GET: begin
        if (s >= 0) begin
          p.value_out = tbl_val[s];
          make_recent(s);
        end
      end
      ACT_DEL: begin
        if (s >= 0) remove_slot(s);
      end
      default: ;
    endcase
    p.memory_usage  = usage[UsageW-1:0];
    p.evicted_count = (ev > 31) ? 5'd31 : ev[EvW-1:0];
    evict_total += ev;
    return p;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch on response %0d: %s got %0h expected %0h", rsp_count, field, got,
             want);
  endtask

  // driver; the prediction for an accepted request is queued at its acceptance edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (in_valid && !in_stall) begin
      expected_rsps.push_back(predict_lookup(in_data));
      if (pending_reqs.size() > 0 && rand_gap() == 0) begin
        in_data <= pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
        in_gap   <= rand_gap();
      end
    end else if (!in_valid) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        in_data  <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap   <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("unexpected response %0d", rsp_count);
        end else begin
          want = expected_rsps.pop_front();
          if (out_data.hit !== want.hit)
            report_mismatch("hit", 32'(out_data.hit), 32'(want.hit));
          if (out_data.value_out !== want.value_out)
            report_mismatch("value_out", out_data.value_out, want.value_out);
          if (out_data.memory_usage !== want.memory_usage)
            report_mismatch("memory_usage", 32'(out_data.memory_usage),
                            32'(want.memory_usage));
          if (out_data.evicted_count !== want.evicted_count)
            report_mismatch("evicted_count", 32'(out_data.evicted_count),
                            32'(want.evicted_count));
        end
        rsp_count++;
      end
      if (out_gap > 0) begin
        out_gap   <= out_gap - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_gap   <= rand_gap();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000 && (pending_reqs.size() > 0 || expected_rsps.size() > 0
          || in_valid)) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic cfg_write(logic [31:0] v);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_BUDGET;
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    budget = v & 32'h1FFFFF;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  function automatic req_t make_req(action_t a, logic [KeyW-1:0] k, logic [ValW-1:0] v,
                                    logic [15:0] b);
    req_t r;
    r.action = a;
    r.key = k;
    r.value_in = v;
    r.payload_bytes = b;
    return r;
  endfunction

  function automatic logic [15:0] rand_bytes();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($urandom_range(0, 300));
    if (r < 8) return 16'($urandom_range(0, 4000));
    return 16'($urandom);
  endfunction

  function automatic req_t rand_req();
    int unsigned  r;
    logic [KeyW-1:0] k;
    r = $urandom_range(0, 99);
    k = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 7) + 0] ^
        KeyW'($urandom_range(0, 2) * 16) : $urandom;
    if (r < 45) return make_req(ACT_SET, k, $urandom, rand_bytes());
    if (r < 75) return make_req(ACT_GET, k, $urandom, 16'($urandom));
    if (r < 95) return make_req(ACT_DEL, k, $urandom, 16'($urandom));
    return make_req(ACT_NOP, k, $urandom, 16'($urandom));
  endfunction

  initial begin
    int unsigned budgets[6];
    in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    errors = 0; rsp_count = 0; evict_total = 0; idle_cycles = 0;
    in_gap = 0; out_gap = 0; budget = 1048576; usage = 0;
    for (int i = 0; i < Entries; i++) begin
      tbl_valid[i] = 1'b0; tbl_rank[i] = 0;
    end
    foreach (key_pool[i]) key_pool[i] = $urandom;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default budget, extremes, all actions, overflow of slots
    pending_reqs.push_back(make_req(ACT_GET, 32'h0, 32'h0, 16'h0));
    pending_reqs.push_back(make_req(ACT_SET, 32'h0, 32'hFFFFFFFF, 16'h0));
    pending_reqs.push_back(make_req(ACT_SET, 32'hFFFFFFFF, 32'h0, 16'hFFFF));
    pending_reqs.push_back(make_req(ACT_GET, 32'h0, 32'h0, 16'h0));
    pending_reqs.push_back(make_req(ACT_SET, 32'h0, 32'h5A5A5A5A, 16'hFFFF));
    pending_reqs.push_back(make_req(ACT_NOP, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF));
    pending_reqs.push_back(make_req(ACT_DEL, 32'hFFFFFFFF, 32'h0, 16'h0));
    pending_reqs.push_back(make_req(ACT_DEL, 32'hFFFFFFFF, 32'h0, 16'h0));
    for (int i = 1; i <= 17; i++)
      pending_reqs.push_back(make_req(ACT_SET, 32'(i), 32'(i * 3), 16'(i)));
    drain();
    // tiny budget: every entry larger than budget
    cfg_write(32'd0);
    for (int i = 0; i < 4; i++)
      pending_reqs.push_back(make_req(ACT_SET, 32'(100 + i), 32'(i), 16'(i * 7)));
    drain();

    budgets = '{32'd600, 32'd3000, 32'h1FFFFF, 32'd40000, 32'd1048576, 32'd0};
    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(budgets[ph] | (ph == 2 ? 32'hFFE00000 : 32'h0));
      for (int n = 0; n < 205; n++) pending_reqs.push_back(rand_req());
      drain();
    end

    $display("responses checked: %0d, evictions seen: %0d, budget phases: 8",
             rsp_count, evict_total);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
